>>> hdl/sfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared widths, frame sizes and codes for the side-by-side frame scaler.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int LEFT_W  = 320;
    localparam int LEFT_H  = 200;
    localparam int RIGHT_W = 640;
    localparam int RIGHT_H = 200;

    localparam int LEFT_DEPTH  = LEFT_W * LEFT_H;
    localparam int RIGHT_DEPTH = RIGHT_W * RIGHT_H;
    localparam int LEFT_AW     = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
    localparam int RIGHT_AW    = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;

    localparam int KIND_W     = 2;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 10;
    localparam int PIX_W      = 32;
    localparam int PANE_W_W   = 11;
    localparam int CANVAS_H_W = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [KIND_W-1:0] KIND_WR_LEFT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_RIGHT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RD       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

    localparam logic [PANE_W_W-1:0]   HALF_WIDTH_RST    = 11'd320;
    localparam logic [CANVAS_H_W-1:0] CANVAS_HEIGHT_RST = 10'd240;

    // left image height is half_width * LH_MUL / 2**LH_SHIFT
    localparam int LH_MUL   = 5;
    localparam int LH_SHIFT = 3;

    localparam int MAX_X   = (LEFT_W > RIGHT_W) ? LEFT_W : RIGHT_W;
    localparam int MAX_Y   = (LEFT_H > RIGHT_H) ? LEFT_H : RIGHT_H;
    localparam int MAX_SRC = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
    localparam int XQ_W    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YQ_W    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;

    localparam int NUM_W = COL_W + $clog2(MAX_SRC + 1);
    localparam int DEN_W = COL_W;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int SD_W  = COL_W + 2;

endpackage

>>> hdl/side_by_side_frame_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// side_by_side_frame_scaler
// Two frame stores composed side by side on a canvas with nearest-neighbor
// scaling; the left frame is letterboxed, the right frame fills the height.
//
//   channel   direction  handshake              payload
//   command   in         start & !busy          kind, col, row, pixel
//   result    out        done (one-cycle pulse) color, blank
//   config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Writes never raise busy. A read that lands in the picture runs two
// bit-serial divisions of NUM_W steps each on one shared divider and one
// RAM read, passing through S_CHECK, S_DIVX, S_DIVY, S_ADDR and S_MEM while
// busy; done rises in the cycle after S_MEM. A blank read is busy only in
// S_CHECK. Reset is asynchronous; the frame stores hold no reset value and
// need no clearing pass. Results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module side_by_side_frame_scaler
    import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     kind,
    input  logic [COL_W-1:0]      col,
    input  logic [ROW_W-1:0]      row,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  done,
    output logic [PIX_W-1:0]      color,
    output logic                  blank,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIVX  = 6'b000100,
        S_DIVY  = 6'b001000,
        S_ADDR  = 6'b010000,
        S_MEM   = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PANE_W_W-1:0]     half_width_reg;
    logic [CANVAS_H_W-1:0]   canvas_height_reg;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic                    left_reg, left_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NUM_W-1:0]        numy_reg, numy_next;
    logic [DEN_W-1:0]        deny_reg, deny_next;
    logic [XQ_W-1:0]         qx_reg, qx_next;
    logic [YQ_W-1:0]         qy_reg, qy_next;
    logic                    done_reg, done_next;
    logic [PIX_W-1:0]        color_reg, color_next;
    logic                    blank_reg, blank_next;

    logic                    accept;
    logic                    left_we, right_we;
    logic [LEFT_AW-1:0]      left_addr, left_wr_idx, left_rd_idx;
    logic [RIGHT_AW-1:0]     right_addr, right_wr_idx, right_rd_idx;
    logic [PIX_W-1:0]        left_rdata, right_rdata;

    logic [COL_W:0]          two_p;
    logic                    outside, in_left, letterbox;
    logic [PANE_W_W+2:0]     p5;
    logic [DEN_W-1:0]        lh;
    logic signed [SD_W-1:0]  diff, top, ydist;
    logic [COL_W-1:0]        cpos_r;
    logic [NUM_W-1:0]        numx_left, numx_right, numy_left, numy_right;

    logic [DEN_W:0]          trial, trial_sub;
    logic                    ge;
    logic [DEN_W-1:0]        rem_step;
    logic [NUM_W-1:0]        num_step;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign color     = color_reg;
    assign blank     = blank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg    <= HALF_WIDTH_RST;
            canvas_height_reg <= CANVAS_H_W'(CANVAS_HEIGHT_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_WIDTH:    half_width_reg    <= cfg_data[PANE_W_W-1:0];
                CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[CANVAS_H_W-1:0];
                default:           half_width_reg    <= half_width_reg;
            endcase
        end
    end

    // store writes
    assign left_we  = accept && (kind == KIND_WR_LEFT) &&
                      (col < COL_W'(LEFT_W)) && (row < ROW_W'(LEFT_H));
    assign right_we = accept && (kind == KIND_WR_RIGHT) &&
                      (col < COL_W'(RIGHT_W)) && (row < ROW_W'(RIGHT_H));

    assign left_wr_idx  = LEFT_AW'(LEFT_AW'(row) * LEFT_AW'(LEFT_W) + LEFT_AW'(col));
    assign right_wr_idx = RIGHT_AW'(RIGHT_AW'(row) * RIGHT_AW'(RIGHT_W) + RIGHT_AW'(col));
    assign left_rd_idx  = LEFT_AW'(LEFT_AW'(qy_reg) * LEFT_AW'(LEFT_W) + LEFT_AW'(qx_reg));
    assign right_rd_idx = RIGHT_AW'(RIGHT_AW'(qy_reg) * RIGHT_AW'(RIGHT_W) +
                          RIGHT_AW'(qx_reg));

    assign left_addr  = (state_reg == S_IDLE) ? left_wr_idx : left_rd_idx;
    assign right_addr = (state_reg == S_IDLE) ? right_wr_idx : right_rd_idx;

    sfs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LEFT_DEPTH)
    ) u_left_ram (
        .clk   (clk),
        .we    (left_we),
        .addr  (left_addr),
        .wdata (pixel),
        .rdata (left_rdata)
    );

    sfs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RIGHT_DEPTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (right_we),
        .addr  (right_addr),
        .wdata (pixel),
        .rdata (right_rdata)
    );

    // canvas geometry of the held read
    always_comb
    begin
        two_p     = {1'b0, half_width_reg} << 1;
        outside   = (half_width_reg == '0) || (canvas_height_reg == '0) ||
                    ({1'b0, col_reg} >= two_p) || (row_reg >= canvas_height_reg);
        in_left   = (col_reg < half_width_reg);
        p5        = (PANE_W_W+3)'(half_width_reg) * (PANE_W_W+3)'(LH_MUL);
        lh        = DEN_W'(p5 >> LH_SHIFT);
        diff      = $signed(SD_W'(canvas_height_reg)) - $signed(SD_W'(lh));
        top       = (diff + $signed(SD_W'(diff[SD_W-1]))) >>> 1;
        ydist     = $signed(SD_W'(row_reg)) - top;
        letterbox = (lh == '0) || ydist[SD_W-1] || (ydist >= $signed(SD_W'(lh)));
        cpos_r    = col_reg - half_width_reg;
        numx_left  = NUM_W'(col_reg) * NUM_W'(LEFT_W);
        numx_right = NUM_W'(cpos_r) * NUM_W'(RIGHT_W);
        numy_left  = NUM_W'(ydist[DEN_W-1:0]) * NUM_W'(LEFT_H);
        numy_right = NUM_W'(row_reg) * NUM_W'(RIGHT_H);
    end

    // one restoring division step
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_step  = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        num_step  = {num_reg[NUM_W-2:0], ge};
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        numy_next  = numy_reg;
        deny_next  = deny_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        done_next  = 1'b0;
        color_next = color_reg;
        blank_next = blank_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (kind == KIND_RD))
                begin
                    col_next   = col;
                    row_next   = row;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (outside || (in_left && letterbox))
                begin
                    done_next  = 1'b1;
                    color_next = '0;
                    blank_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    left_next  = in_left;
                    num_next   = in_left ? numx_left : numx_right;
                    den_next   = half_width_reg;
                    numy_next  = in_left ? numy_left : numy_right;
                    deny_next  = in_left ? lh : DEN_W'(canvas_height_reg);
                    rem_next   = '0;
                    cnt_next   = CNT_W'(NUM_W - 1);
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    qx_next    = num_step[XQ_W-1:0];
                    num_next   = numy_reg;
                    den_next   = deny_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(NUM_W - 1);
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    qy_next    = num_step[YQ_W-1:0];
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_MEM;
            end
            S_MEM:
            begin
                done_next  = 1'b1;
                color_next = left_reg ? left_rdata : right_rdata;
                blank_next = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        left_reg  <= left_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        numy_reg  <= numy_next;
        deny_reg  <= deny_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        color_reg <= color_next;
        blank_reg <= blank_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is in progress");

    a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && blank) |-> (color == '0))
        else $error("blank result carries a nonzero color");

    a_store_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (left_we || right_we) |-> (state_reg == S_IDLE))
        else $error("store write during a read transaction");

    a_src_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDR) |->
        (left_reg ? ((qx_reg < XQ_W'(LEFT_W)) && (qy_reg < YQ_W'(LEFT_H)))
                  : ((qx_reg < XQ_W'(RIGHT_W)) && (qy_reg < YQ_W'(RIGHT_H)))))
        else $error("scaled source position beyond frame");

endmodule

>>> hdl/sfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
